@@ hw/rtl/jdc_pkg.sv @@
package jdc_pkg;

   // Number of register stages from the request register to the response register.
   localparam int unsigned STAGES = 8;

   // Direction of a conversion, carried in the action field of a request.
   localparam logic ACT_TO_JD  = 1'b0;
   localparam logic ACT_TO_CAL = 1'b1;

   // Whole days in k months of 30.6001 days. This is the month offset of the day
   // count, with March as month 3.
   function automatic logic [9:0] month_span(input logic [4:0] k);
      logic [9:0] span;
      case (k)
         5'd3:    span = 10'd91;
         5'd4:    span = 10'd122;
         5'd5:    span = 10'd153;
         5'd6:    span = 10'd183;
         5'd7:    span = 10'd214;
         5'd8:    span = 10'd244;
         5'd9:    span = 10'd275;
         5'd10:   span = 10'd306;
         5'd11:   span = 10'd336;
         5'd12:   span = 10'd367;
         5'd13:   span = 10'd397;
         5'd14:   span = 10'd428;
         5'd15:   span = 10'd459;
         5'd16:   span = 10'd489;
         5'd17:   span = 10'd520;
         default: span = 10'd0;
      endcase
      return span;
   endfunction

endpackage

@@ hw/rtl/jdc_to_jd.sv @@
module jdc_to_jd (
   input  logic                        clock,
   input  logic [jdc_pkg::STAGES-1:0]  load,
   input  logic signed [14:0]          cal_year,
   input  logic [3:0]                  cal_month,
   input  logic [4:0]                  cal_day,
   input  logic [4:0]                  cal_hour,
   input  logic [5:0]                  cal_minute,
   input  logic [5:0]                  cal_second,
   output logic [22:0]                 day_number,
   output logic [16:0]                 seconds_of_day
);

   localparam int unsigned DELAY = jdc_pkg::STAGES - 2;

   localparam logic signed [14:0] REFORM_YEAR  = 15'sd1582;
   localparam logic [3:0]         REFORM_MONTH = 4'd9;
   localparam logic [4:0]         REFORM_MDAY  = 5'd5;

   // Request register.
   logic signed [14:0] year_ff;
   logic [3:0]         month_ff;
   logic [4:0]         mday_ff;
   logic [4:0]         hour_ff;
   logic [5:0]         minute_ff;
   logic [5:0]         second_ff;

   // Second stage.
   logic [8:0]         cent_ff, cent_in;
   logic signed [27:0] base_ff, base_in;
   logic               julian_ff, julian_in;
   logic [9:0]         mspan_ff, mspan_in;
   logic [4:0]         mday2_ff;
   logic [16:0]        sod_ff, sod_in;

   logic               early;
   logic signed [15:0] y_v;
   logic [15:0]        u_v;
   logic [28:0]        cent_prod;
   logic signed [27:0] x_v;
   logic signed [27:0] base_prod;
   logic [4:0]         span_idx;

   logic signed [10:0] cent_s;
   logic signed [10:0] greg_corr;
   logic [27:0]        day_sum;
   logic [22:0]        day_in;

   logic [22:0] day_ff [DELAY];
   logic [16:0] sec_ff [DELAY];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         year_ff   <= cal_year;
         month_ff  <= cal_month;
         mday_ff   <= cal_day;
         hour_ff   <= cal_hour;
         minute_ff <= cal_minute;
         second_ff <= cal_second;
      end
   end

   always_comb begin
      // January and February count as months 13 and 14 of the year before.
      early = (month_ff <= 4'd1);
      y_v   = early ? 16'(year_ff) - 16'sd1 : 16'(year_ff);

      // floor(y / 100): offset by a multiple of 100 so the dividend is positive,
      // then multiply by the reciprocal 5243 / 2^19.
      u_v       = 16'(y_v + 16'sd16400);
      cent_prod = 29'(u_v) * 29'd5243;
      cent_in   = cent_prod[27:19];

      x_v       = 28'(y_v) + 28'sd4716;
      base_prod = x_v * 28'sd1461;
      base_in   = base_prod >>> 2;

      if (early) begin
         span_idx = {1'b0, month_ff} + 5'd14;
      end else begin
         span_idx = {1'b0, month_ff} + 5'd2;
      end
      mspan_in = jdc_pkg::month_span(span_idx);

      julian_in = (year_ff < REFORM_YEAR) ||
                  ((year_ff == REFORM_YEAR) &&
                   ((month_ff < REFORM_MONTH) ||
                    ((month_ff == REFORM_MONTH) && (mday_ff < REFORM_MDAY))));

      sod_in = 17'(hour_ff) * 17'd3600 + 17'(minute_ff) * 17'd60 + 17'(second_ff);
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         cent_ff   <= cent_in;
         base_ff   <= base_in;
         julian_ff <= julian_in;
         mspan_ff  <= mspan_in;
         mday2_ff  <= mday_ff;
         sod_ff    <= sod_in;
      end
   end

   always_comb begin
      // Remove the offset of 164 centuries again.
      cent_s = $signed(11'(cent_ff)) - 11'sd164;
      if (julian_ff) begin
         greg_corr = 11'sd0;
      end else begin
         greg_corr = 11'sd2 - cent_s + (cent_s >>> 2);
      end
      day_sum = base_ff + 28'(mspan_ff) + 28'(mday2_ff) + 28'(greg_corr) - 28'd1524;
      day_in  = day_sum[22:0];
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         day_ff[0] <= day_in;
         sec_ff[0] <= sod_ff;
      end
   end

   for (genvar i = 1; i < DELAY; i++) begin : g_delay
      always_ff @(posedge clock) begin
         if (load[i + 2]) begin
            day_ff[i] <= day_ff[i - 1];
            sec_ff[i] <= sec_ff[i - 1];
         end
      end
   end

   assign day_number     = day_ff[DELAY - 1];
   assign seconds_of_day = sec_ff[DELAY - 1];

endmodule

@@ hw/rtl/jdc_to_cal.sv @@
module jdc_to_cal (
   input  logic                        clock,
   input  logic [jdc_pkg::STAGES-1:0]  load,
   input  logic [22:0]                 in_day_number,
   input  logic [16:0]                 in_seconds,
   output logic signed [14:0]          year,
   output logic [3:0]                  month,
   output logic [4:0]                  day_of_month,
   output logic [4:0]                  hour,
   output logic [5:0]                  minute,
   output logic [5:0]                  second
);

   localparam logic [16:0] SECS_PER_DAY = 17'd86400;
   localparam logic [23:0] REFORM_DAY   = 24'd2299161;
   localparam logic [26:0] ALPHA_OFS    = 27'd7468865;
   localparam logic [25:0] CYCLE_DAYS   = 26'd146097;
   localparam logic [27:0] YEAR_DIV     = 28'd7305;

   typedef struct packed {
      logic [22:0] z;
      logic [16:0] secs;
   } st1_type;

   typedef struct packed {
      logic [23:0] z;
      logic [24:0] n;
      logic [7:0]  alpha0;
      logic        greg;
      logic [16:0] secs;
      logic [4:0]  hour;
   } st2_type;

   typedef struct packed {
      logic [23:0] z;
      logic        greg;
      logic [7:0]  alpha;
      logic [4:0]  hour;
      logic [11:0] rem;
   } st3_type;

   typedef struct packed {
      logic [23:0] b;
      logic [27:0] n;
      logic [4:0]  hour;
      logic [11:0] rem;
      logic [5:0]  minute;
   } st4_type;

   typedef struct packed {
      logic [23:0] b;
      logic [27:0] n;
      logic [14:0] c0;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } st5_type;

   typedef struct packed {
      logic [23:0] b;
      logic [14:0] c;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } st6_type;

   typedef struct packed {
      logic [8:0]  t;
      logic [14:0] c;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } st7_type;

   typedef struct packed {
      logic [14:0] year;
      logic [3:0]  month;
      logic [4:0]  mday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } st8_type;

   st1_type s1_ff, s1_in;
   st2_type s2_ff, s2_in;
   st3_type s3_ff, s3_in;
   st4_type s4_ff, s4_in;
   st5_type s5_ff, s5_in;
   st6_type s6_ff, s6_in;
   st7_type s7_ff, s7_in;
   st8_type s8_ff, s8_in;

   logic        wrap_v;
   logic [16:0] secs_v;
   logic [23:0] z_v;
   logic [26:0] n_v;
   logic [22:0] alpha_prod;
   logic [25:0] hour_prod;
   logic [25:0] cycle_prod;
   logic [25:0] cycle_rem;
   logic [23:0] a_v;
   logic [23:0] b_v;
   logic [20:0] min_prod;
   logic [35:0] year_prod;
   logic [27:0] year_rem;
   logic [25:0] d_prod;
   logic [23:0] t_full;
   logic [3:0]  e_v;
   logic [3:0]  mm_v;
   logic [15:0] yy_v;

   assign s1_in = '{z: in_day_number, secs: in_seconds};

   // Stage 1 to 2: carry a full day out of the seconds, estimate the century
   // correction and the hour.
   always_comb begin
      wrap_v = (s1_ff.secs >= SECS_PER_DAY);
      secs_v = wrap_v ? s1_ff.secs - SECS_PER_DAY : s1_ff.secs;
      z_v    = 24'(s1_ff.z) + 24'(wrap_v);
      n_v    = {1'b0, z_v, 2'b00} - ALPHA_OFS;
      // 229 / 2^25 sits just below 1 / 146097, so the estimate is low by at most one.
      alpha_prod = 23'(n_v[24:10]) * 23'd229;
      hour_prod  = 26'(secs_v[16:4]) * 26'd4661;

      s2_in.z      = z_v;
      s2_in.n      = n_v[24:0];
      s2_in.alpha0 = alpha_prod[22:15];
      s2_in.greg   = (z_v >= REFORM_DAY);
      s2_in.secs   = secs_v;
      s2_in.hour   = hour_prod[24:20];
   end

   // Stage 2 to 3: correct the century estimate; seconds left in the hour.
   always_comb begin
      cycle_prod = 26'(s2_ff.alpha0) * CYCLE_DAYS;
      cycle_rem  = 26'(s2_ff.n) - cycle_prod;

      s3_in.z     = s2_ff.z;
      s3_in.greg  = s2_ff.greg;
      s3_in.alpha = s2_ff.alpha0 + 8'(cycle_rem >= CYCLE_DAYS);
      s3_in.hour  = s2_ff.hour;
      s3_in.rem   = 12'(s2_ff.secs - 17'(s2_ff.hour) * 17'd3600);
   end

   // Stage 3 to 4: day count from the calendar epoch and the minute.
   always_comb begin
      if (s3_ff.greg) begin
         a_v = s3_ff.z + 24'd1 + 24'(s3_ff.alpha) - 24'(s3_ff.alpha[7:2]);
      end else begin
         a_v = s3_ff.z;
      end
      b_v      = a_v + 24'd1524;
      min_prod = 21'(s3_ff.rem[11:2]) * 21'd1093;

      s4_in.b      = b_v;
      s4_in.n      = 28'(b_v) * 28'd20 - 28'd2442;
      s4_in.hour   = s3_ff.hour;
      s4_in.rem    = s3_ff.rem;
      s4_in.minute = min_prod[19:14];
   end

   // Stage 4 to 5: estimate of the year count, low by at most one.
   always_comb begin
      year_prod = 36'(s4_ff.n[27:8]) * 36'd73493;

      s5_in.b      = s4_ff.b;
      s5_in.n      = s4_ff.n;
      s5_in.c0     = year_prod[35:21];
      s5_in.hour   = s4_ff.hour;
      s5_in.minute = s4_ff.minute;
      s5_in.second = 6'(s4_ff.rem - 12'(s4_ff.minute) * 12'd60);
   end

   // Stage 5 to 6: correct the year count.
   always_comb begin
      year_rem = s5_ff.n - 28'(s5_ff.c0) * YEAR_DIV;

      s6_in.b      = s5_ff.b;
      s6_in.c      = s5_ff.c0 + 15'(year_rem >= YEAR_DIV);
      s6_in.hour   = s5_ff.hour;
      s6_in.minute = s5_ff.minute;
      s6_in.second = s5_ff.second;
   end

   // Stage 6 to 7: days into the March-based year, always within 123 to 488.
   always_comb begin
      d_prod = 26'(s6_ff.c) * 26'd1461;
      t_full = s6_ff.b - d_prod[25:2];

      s7_in.t      = t_full[8:0];
      s7_in.c      = s6_ff.c;
      s7_in.hour   = s6_ff.hour;
      s7_in.minute = s6_ff.minute;
      s7_in.second = s6_ff.second;
   end

   // Stage 7 to 8: month by threshold search, then day of month and year.
   always_comb begin
      e_v = 4'd3;
      for (int k = 4; k <= 15; k++) begin
         if (10'(s7_ff.t) > jdc_pkg::month_span(5'(k))) begin
            e_v = 4'(k);
         end
      end
      mm_v = (e_v < 4'd14) ? e_v - 4'd1 : e_v - 4'd13;
      yy_v = (mm_v > 4'd2) ? 16'(s7_ff.c) - 16'd4716 : 16'(s7_ff.c) - 16'd4715;

      s8_in.year   = yy_v[14:0];
      s8_in.month  = mm_v - 4'd1;
      s8_in.mday   = 5'(10'(s7_ff.t) - jdc_pkg::month_span({1'b0, e_v}));
      s8_in.hour   = s7_ff.hour;
      s8_in.minute = s7_ff.minute;
      s8_in.second = s7_ff.second;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_ff <= s1_in;
      end
      if (load[1]) begin
         s2_ff <= s2_in;
      end
      if (load[2]) begin
         s3_ff <= s3_in;
      end
      if (load[3]) begin
         s4_ff <= s4_in;
      end
      if (load[4]) begin
         s5_ff <= s5_in;
      end
      if (load[5]) begin
         s6_ff <= s6_in;
      end
      if (load[6]) begin
         s7_ff <= s7_in;
      end
      if (load[7]) begin
         s8_ff <= s8_in;
      end
   end

   assign year         = $signed(s8_ff.year);
   assign month        = s8_ff.month;
   assign day_of_month = s8_ff.mday;
   assign hour         = s8_ff.hour;
   assign minute       = s8_ff.minute;
   assign second       = s8_ff.second;

endmodule

@@ hw/rtl/julian_day_conversion.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  action, calendar date and time, day and seconds
// rsp       out        rsp_valid / rsp_ready  day number, seconds, calendar date and time
//
// One request enters per cycle while req_ready is high; its response is valid when the request
// reaches the last of the eight register stages of the day number to calendar path.
// Every stage has its own valid bit, so bubbles close up and requests keep entering
// while a response waits; req_ready falls only when all eight stages are full.
// Reset is synchronous and clears the stage valid bits only.
module julian_day_conversion (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [14:0] req_cal_year,
   input  logic [3:0]         req_cal_month,
   input  logic [4:0]         req_cal_day,
   input  logic [4:0]         req_cal_hour,
   input  logic [5:0]         req_cal_minute,
   input  logic [5:0]         req_cal_second,
   input  logic [22:0]        req_in_day_number,
   input  logic [16:0]        req_in_seconds,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [22:0]        rsp_day_number,
   output logic [16:0]        rsp_seconds_of_day,
   output logic signed [14:0] rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day_of_month,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second
);

   localparam int unsigned N = jdc_pkg::STAGES;

   logic [N-1:0] valid_ff, valid_in;
   logic [N-1:0] act_ff, act_in;
   logic [N:0]   ready_chain;
   logic [N-1:0] load;
   logic         to_cal;

   logic [22:0]        jd_day;
   logic [16:0]        jd_sod;
   logic signed [14:0] cal_year;
   logic [3:0]         cal_month;
   logic [4:0]         cal_mday;
   logic [4:0]         cal_hour;
   logic [5:0]         cal_minute;
   logic [5:0]         cal_second;

   // A stage can take new data when it is empty or its contents move on.
   always_comb begin
      ready_chain[N] = rsp_ready;
      for (int k = N - 1; k >= 0; k--) begin
         ready_chain[k] = !valid_ff[k] || ready_chain[k + 1];
      end
   end

   assign load      = ready_chain[N-1:0];
   assign req_ready = ready_chain[0];
   assign valid_in  = (load & {valid_ff[N-2:0], req_valid}) | (~load & valid_ff);
   assign act_in    = (load & {act_ff[N-2:0], req_action}) | (~load & act_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
   end

   jdc_to_jd u_to_jd (
      .clock          (clock),
      .load           (load),
      .cal_year       (req_cal_year),
      .cal_month      (req_cal_month),
      .cal_day        (req_cal_day),
      .cal_hour       (req_cal_hour),
      .cal_minute     (req_cal_minute),
      .cal_second     (req_cal_second),
      .day_number     (jd_day),
      .seconds_of_day (jd_sod)
   );

   jdc_to_cal u_to_cal (
      .clock         (clock),
      .load          (load),
      .in_day_number (req_in_day_number),
      .in_seconds    (req_in_seconds),
      .year          (cal_year),
      .month         (cal_month),
      .day_of_month  (cal_mday),
      .hour          (cal_hour),
      .minute        (cal_minute),
      .second        (cal_second)
   );

   // Fields that the other direction produces read as zero.
   assign to_cal    = (act_ff[N-1] == jdc_pkg::ACT_TO_CAL);
   assign rsp_valid = valid_ff[N-1];

   assign rsp_day_number     = to_cal ? '0 : jd_day;
   assign rsp_seconds_of_day = to_cal ? '0 : jd_sod;
   assign rsp_year           = to_cal ? cal_year : '0;
   assign rsp_month          = to_cal ? cal_month : '0;
   assign rsp_day_of_month   = to_cal ? cal_mday : '0;
   assign rsp_hour           = to_cal ? cal_hour : '0;
   assign rsp_minute         = to_cal ? cal_minute : '0;
   assign rsp_second         = to_cal ? cal_second : '0;

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff))
      else $error("request side stalled while a pipeline stage is empty");

   a_time_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && to_cal) |->
         (rsp_hour <= 5'd23) && (rsp_minute <= 6'd59) && (rsp_second <= 6'd59))
      else $error("time of day out of range on a calendar response");

   a_date_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && to_cal) |->
         (rsp_month <= 4'd11) && (rsp_day_of_month >= 5'd1) && (rsp_day_of_month <= 5'd31))
      else $error("month or day of month out of range on a calendar response");

endmodule
